// File: hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int PRIO_W    = 16;
    localparam int TAG_PORT_W = 16;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Request operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // One stored entry as seen between cells
    typedef struct packed {
        logic        [TAG_PORT_W-1:0] tag;
        logic signed [PRIO_W-1:0]     prio;
    } spq_entry_t;

    // Broadcast control to the whole chain
    typedef struct packed {
        cell_op_t   op;
        spq_entry_t new_entry;
    } spq_ctl_t;

endpackage

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue, a chain of CAPACITY cells kept in descending
// priority order, head in cell 0.
// Request channel s_axis: tuser carries the command (insert, pop, list),
// tdata the tag and the signed priority of an insert.
// Result channel m_axis: tuser carries the status, tdata the tag and the
// priority of a popped or listed entry, tlast marks the final result of
// a request.
// Insert and pop are done at the edge that takes them: the whole chain
// shifts at once and the single result is registered at that edge, valid
// in the cycle after, so these requests can be taken back to back. A list
// request streams one entry per cycle, while the receiver keeps up, by
// rotating the chain through the head cell; its first entry is registered
// once the block is in its list state, and no request is taken until the
// last entry is registered. A list of an empty queue gives a single
// ST_EMPTY result. A request of unused command code produces nothing.
// Reset empties the queue and drops any pending result.
// A stalled receiver holds the output register; a new request is taken
// only while that register is free or being read in the same cycle.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // tag[15:0], priority_req[31:16]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_tag[15:0], out_priority[31:16]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    status_t           m_status_reg;
    status_t           m_status_next;
    spq_entry_t        m_entry_reg;
    spq_entry_t        m_entry_next;
    logic              m_last_reg;
    logic              m_last_next;

    spq_ctl_t          ctl;
    spq_entry_t        cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_lower;

    logic   out_free;
    logic   accept;
    logic   full;
    logic   empty;
    cmd_t   cmd;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = cell_valid[CAPACITY-1];
    assign empty         = !cell_valid[0];
    assign cmd           = cmd_t'(s_axis_tuser);

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_entry_t left_entry;
        spq_entry_t right_entry;
        logic       left_valid;
        logic       left_lower;
        logic       right_valid;

        if (i == 0)
        begin : g_head
            assign left_entry = cell_entry[0];
            assign left_valid = 1'b1;
            assign left_lower = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_lower = cell_lower[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
            assign right_valid = cell_valid[i+1];
        end

        spq_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .head_entry  (cell_entry[0]),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_lower  (left_lower),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .lower       (cell_lower[i])
        );
    end

    // Chain command and next control state
    always_comb
    begin
        ctl.op             = OP_HOLD;
        ctl.new_entry.tag  = s_axis_tdata[15:0];
        ctl.new_entry.prio = s_axis_tdata[31:16];
        state_next         = state_reg;
        fill_count_next    = fill_count_reg;
        remain_next        = remain_reg;
        m_valid_next       = m_valid_reg && !m_axis_tready;
        m_status_next      = m_status_reg;
        m_entry_next       = m_entry_reg;
        m_last_next        = m_last_reg;

        if (accept)
        begin
            unique case (cmd)
                CMD_INSERT:
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = full ? ST_FULL : ST_OK;
                    m_entry_next  = '0;
                    m_last_next   = 1'b1;
                    if (!full)
                    begin
                        ctl.op          = OP_INSERT;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = empty ? ST_EMPTY : ST_OK;
                    m_entry_next  = empty ? '0 : cell_entry[0];
                    m_last_next   = 1'b1;
                    if (!empty)
                    begin
                        ctl.op          = OP_POP;
                        fill_count_next = fill_count_reg - CNT_W'(1);
                    end
                end
                CMD_LIST:
                begin
                    if (empty)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_EMPTY;
                        m_entry_next  = '0;
                        m_last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next  = S_LIST;
                        remain_next = fill_count_reg;
                    end
                end
                default:
                begin
                    ctl.op = OP_HOLD;
                end
            endcase
        end
        else if (state_reg == S_LIST && out_free)
        begin
            // emit the head, rotate it to the tail
            ctl.op        = OP_ROTATE;
            m_valid_next  = 1'b1;
            m_status_next = ST_OK;
            m_entry_next  = cell_entry[0];
            m_last_next   = (remain_reg == CNT_W'(1));
            remain_next   = remain_reg - CNT_W'(1);
            if (remain_reg == CNT_W'(1))
                state_next = S_IDLE;
        end
    end

    // Control state and output register flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            remain_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            remain_reg     <= remain_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {m_entry_reg.prio, m_entry_reg.tag};
    assign m_axis_tlast  = m_last_reg;

    // Occupancy bits agree with the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(fill_count_reg))
    else $error("cell occupancy does not match fill count");

    // Occupied cells form a run from the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("gap in the cell chain");

    // No request is taken while a list streams
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> !s_axis_tready)
    else $error("request taken during list");

    // A pop of a non-empty queue removes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_POP && !empty |=>
            fill_count_reg == $past(fill_count_reg) - CNT_W'(1))
    else $error("pop did not shrink the queue");

endmodule

// File: hw/rtl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_W = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  spq_ctl_t   ctl,
    input  spq_entry_t head_entry,   // entry of cell 0, used for rotation
    input  spq_entry_t left_entry,
    input  logic       left_valid,   // tied high for the head cell
    input  logic       left_lower,   // tied low for the head cell
    input  spq_entry_t right_entry,
    input  logic       right_valid,  // tied low for the tail cell
    output spq_entry_t entry,
    output logic       valid,
    output logic       lower
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [TAG_W-1:0]         tag_reg;
    logic [TAG_W-1:0]         tag_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;

    // New entry goes at or before this cell
    assign lower = !valid_reg || (prio_reg < ctl.new_entry.prio);

    // Next contents of this cell
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                valid_next = valid_reg | left_valid;
                if (lower)
                begin
                    if (left_lower)
                    begin
                        tag_next  = left_entry.tag[TAG_W-1:0];
                        prio_next = left_entry.prio;
                    end
                    else
                    begin
                        tag_next  = ctl.new_entry.tag[TAG_W-1:0];
                        prio_next = ctl.new_entry.prio;
                    end
                end
            end
            OP_POP:
            begin
                valid_next = right_valid;
                tag_next   = right_entry.tag[TAG_W-1:0];
                prio_next  = right_entry.prio;
            end
            OP_ROTATE:
            begin
                // last occupied cell takes the entry of the head, which wraps around
                if (valid_reg)
                begin
                    tag_next  = right_valid ? right_entry.tag[TAG_W-1:0]
                                            : head_entry.tag[TAG_W-1:0];
                    prio_next = right_valid ? right_entry.prio : head_entry.prio;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign valid      = valid_reg;
    assign entry.tag  = TAG_PORT_W'(tag_reg);
    assign entry.prio = prio_reg;

endmodule
